@@ rtl/mtep_pkg.sv @@
// Shared types, constants and helper functions for the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  // Sizes of the variable-length quantity and of the track clock
  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned CLOCK_W          = 32;
  localparam int unsigned VLQ_W            = 28;
  localparam int unsigned VLQ_CNT_W        = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned TEMPO_W          = 24;
  localparam int unsigned EVENT_TIME_W     = 32;

  // Byte codes
  localparam logic [7:0] META_STATUS   = 8'hff;
  localparam logic [7:0] META_END      = 8'h2f;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [3:0] NIB_SYSTEM    = 4'hf;
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_AT   = 4'ha;
  localparam logic [3:0] NIB_CTRL      = 4'hb;
  localparam logic [3:0] NIB_PROGRAM   = 4'hc;
  localparam logic [3:0] NIB_CHAN_AT   = 4'hd;

  // Result kinds
  localparam logic [3:0] KIND_NOTE_OFF = 4'd0;
  localparam logic [3:0] KIND_NOTE_ON  = 4'd1;
  localparam logic [3:0] KIND_POLY_AT  = 4'd2;
  localparam logic [3:0] KIND_CTRL     = 4'd3;
  localparam logic [3:0] KIND_PROGRAM  = 4'd4;
  localparam logic [3:0] KIND_CHAN_AT  = 4'd5;
  localparam logic [3:0] KIND_PITCH    = 4'd6;
  localparam logic [3:0] KIND_TEMPO    = 4'd7;
  localparam logic [3:0] KIND_END      = 4'd8;
  localparam logic [3:0] KIND_ERROR    = 4'd9;

  // Parser phases
  typedef enum logic [7:0] {
    PH_DELTA     = 8'b0000_0001,
    PH_STATUS    = 8'b0000_0010,
    PH_DATA1     = 8'b0000_0100,
    PH_DATA2     = 8'b0000_1000,
    PH_META_TYPE = 8'b0001_0000,
    PH_LEN       = 8'b0010_0000,
    PH_TEMPO     = 8'b0100_0000,
    PH_SKIP      = 8'b1000_0000
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_track;
  } byte_item_t;

  // Output transaction
  typedef struct packed {
    logic [3:0]              kind;
    logic [3:0]              channel;
    logic [7:0]              data0;
    logic [7:0]              data1;
    logic [TEMPO_W-1:0]      tempo_usec;
    logic [VLQ_W-1:0]        delta_ticks;
    logic [EVENT_TIME_W-1:0] event_time;
  } event_item_t;

  // Parser status towards the top level
  typedef struct packed {
    logic push;
    logic finished;
  } core_status_t;

  // Channel messages with a single data byte
  function automatic logic one_data(input logic [7:0] status);
    one_data = (status[7:4] == NIB_PROGRAM) || (status[7:4] == NIB_CHAN_AT);
  endfunction

  // Map a status and second data byte to a result kind
  function automatic logic [3:0] kind_of(input logic [7:0] status, input logic [7:0] d1);
    logic [3:0] k;
    unique case (status[7:4])
      NIB_NOTE_OFF: k = KIND_NOTE_OFF;
      NIB_NOTE_ON:  k = (d1 == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      NIB_POLY_AT:  k = KIND_POLY_AT;
      NIB_CTRL:     k = KIND_CTRL;
      NIB_PROGRAM:  k = KIND_PROGRAM;
      NIB_CHAN_AT:  k = KIND_CHAN_AT;
      default:      k = KIND_PITCH;
    endcase
    kind_of = k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mtep_core.sv @@
// Parser state registers and the per-byte next-state and result logic.
`default_nettype none

module mtep_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  fire,
  input  mtep_pkg::byte_item_t item,
  output mtep_pkg::event_item_t result,
  output mtep_pkg::core_status_t status
);
  import mtep_pkg::*;

  // State registers
  phase_t                phase;
  logic [7:0]            running_status;
  logic [7:0]            current_status;
  logic [VLQ_W-1:0]      length_accum;
  logic [VLQ_CNT_W-1:0]  length_bytes_seen;
  logic [7:0]            first_data_hold;
  logic [7:0]            meta_kind;
  logic [VLQ_W-1:0]      skip_remaining;
  logic [TEMPO_W-1:0]    tempo_accum;
  logic [1:0]            tempo_bytes_seen;
  logic [CLOCK_W-1:0]    track_clock;
  logic                  track_finished;
  logic [VLQ_W-1:0]      delta_hold;

  // Next values
  phase_t                phase_next;
  logic [7:0]            running_status_next;
  logic [7:0]            current_status_next;
  logic [VLQ_W-1:0]      length_accum_next;
  logic [VLQ_CNT_W-1:0]  length_bytes_seen_next;
  logic [7:0]            first_data_hold_next;
  logic [7:0]            meta_kind_next;
  logic [VLQ_W-1:0]      skip_remaining_next;
  logic [TEMPO_W-1:0]    tempo_accum_next;
  logic [1:0]            tempo_bytes_seen_next;
  logic [CLOCK_W-1:0]    track_clock_next;
  logic                  track_finished_next;
  logic [VLQ_W-1:0]      delta_hold_next;

  logic                  push;
  logic [3:0]            r_kind;
  logic [3:0]            r_channel;
  logic [7:0]            r_data0;
  logic [7:0]            r_data1;
  logic [TEMPO_W-1:0]    r_tempo;

  // Work out the effect of one byte
  always_comb begin
    logic [7:0]           b;
    logic [VLQ_W-1:0]     vlq_base;
    logic [VLQ_W-1:0]     vlq_val;
    logic [VLQ_CNT_W-1:0] vlq_cnt;
    logic                 vlq_done;
    logic [TEMPO_W-1:0]   tempo_val;
    logic [1:0]           tempo_cnt;
    logic [VLQ_W-1:0]     skip_val;
    logic [7:0]           chan_status;

    b = item.data_byte;

    // Start from reset values when a new track begins
    if (item.start_of_track) begin
      phase_next             = PH_DELTA;
      running_status_next    = '0;
      current_status_next    = '0;
      length_accum_next      = '0;
      length_bytes_seen_next = '0;
      first_data_hold_next   = '0;
      meta_kind_next         = '0;
      skip_remaining_next    = '0;
      tempo_accum_next       = '0;
      tempo_bytes_seen_next  = '0;
      track_clock_next       = '0;
      track_finished_next    = 1'b0;
      delta_hold_next        = '0;
    end else begin
      phase_next             = phase;
      running_status_next    = running_status;
      current_status_next    = current_status;
      length_accum_next      = length_accum;
      length_bytes_seen_next = length_bytes_seen;
      first_data_hold_next   = first_data_hold;
      meta_kind_next         = meta_kind;
      skip_remaining_next    = skip_remaining;
      tempo_accum_next       = tempo_accum;
      tempo_bytes_seen_next  = tempo_bytes_seen;
      track_clock_next       = track_clock;
      track_finished_next    = track_finished;
      delta_hold_next        = delta_hold;
    end

    push      = 1'b0;
    r_kind    = KIND_NOTE_OFF;
    r_channel = '0;
    r_data0   = '0;
    r_data1   = '0;
    r_tempo   = '0;

    // Variable-length accumulation, shared by delta time and length
    vlq_base = (phase_next == PH_DELTA && length_bytes_seen_next == '0) ? '0
             : length_accum_next;
    vlq_val  = {vlq_base[VLQ_W-8:0], b[6:0]};
    vlq_cnt  = length_bytes_seen_next + VLQ_CNT_W'(1);
    vlq_done = !b[7] || (vlq_cnt >= VLQ_CNT_W'(MAX_LENGTH_BYTES));

    tempo_val = {tempo_accum_next[TEMPO_W-9:0], b};
    tempo_cnt = tempo_bytes_seen_next + 2'd1;

    skip_val = (skip_remaining_next != '0) ? skip_remaining_next - VLQ_W'(1) : '0;

    chan_status = current_status_next;

    if (!track_finished_next) begin
      unique case (phase_next)
        PH_DELTA: begin
          if (vlq_done) begin
            delta_hold_next        = vlq_val;
            track_clock_next       = track_clock_next + CLOCK_W'(vlq_val);
            length_accum_next      = '0;
            length_bytes_seen_next = '0;
            phase_next             = PH_STATUS;
          end else begin
            length_accum_next      = vlq_val;
            length_bytes_seen_next = vlq_cnt;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == META_STATUS) begin
              phase_next = PH_META_TYPE;
            end else if (b[7:4] == NIB_SYSTEM) begin
              meta_kind_next         = '0;
              length_accum_next      = '0;
              length_bytes_seen_next = '0;
              phase_next             = PH_LEN;
            end else begin
              running_status_next = b;
              current_status_next = b;
              phase_next          = PH_DATA1;
            end
          end else if (running_status_next == '0) begin
            // Data byte with no running status: report and drop
            push       = 1'b1;
            r_kind     = KIND_ERROR;
            r_data0    = b;
            phase_next = PH_DELTA;
          end else begin
            // Running status: this byte is the first data byte
            chan_status         = running_status_next;
            current_status_next = running_status_next;
            if (one_data(chan_status)) begin
              push       = 1'b1;
              r_kind     = kind_of(chan_status, 8'd0);
              r_channel  = chan_status[3:0];
              r_data0    = b;
              phase_next = PH_DELTA;
            end else begin
              first_data_hold_next = b;
              phase_next           = PH_DATA2;
            end
          end
        end
        PH_DATA1: begin
          if (one_data(chan_status)) begin
            push       = 1'b1;
            r_kind     = kind_of(chan_status, 8'd0);
            r_channel  = chan_status[3:0];
            r_data0    = b;
            phase_next = PH_DELTA;
          end else begin
            first_data_hold_next = b;
            phase_next           = PH_DATA2;
          end
        end
        PH_DATA2: begin
          push       = 1'b1;
          r_kind     = kind_of(chan_status, b);
          r_channel  = chan_status[3:0];
          r_data0    = first_data_hold_next;
          r_data1    = b;
          phase_next = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_kind_next = b;
          if (b == META_END) begin
            track_finished_next = 1'b1;
            push                = 1'b1;
            r_kind              = KIND_END;
            phase_next          = PH_DELTA;
          end else begin
            length_accum_next      = '0;
            length_bytes_seen_next = '0;
            phase_next             = PH_LEN;
          end
        end
        PH_LEN: begin
          if (vlq_done) begin
            priority if (meta_kind_next == META_TEMPO && vlq_cnt == VLQ_CNT_W'(1)
                         && vlq_val == VLQ_W'(3)) begin
              tempo_accum_next      = '0;
              tempo_bytes_seen_next = '0;
              phase_next            = PH_TEMPO;
            end else if (vlq_val == '0) begin
              phase_next = PH_DELTA;
            end else begin
              skip_remaining_next = vlq_val;
              phase_next          = PH_SKIP;
            end
            length_accum_next      = '0;
            length_bytes_seen_next = '0;
          end else begin
            length_accum_next      = vlq_val;
            length_bytes_seen_next = vlq_cnt;
          end
        end
        PH_TEMPO: begin
          tempo_accum_next = tempo_val;
          if (tempo_cnt == 2'd3) begin
            tempo_bytes_seen_next = '0;
            push                  = 1'b1;
            r_kind                = KIND_TEMPO;
            r_tempo               = tempo_val;
            phase_next            = PH_DELTA;
          end else begin
            tempo_bytes_seen_next = tempo_cnt;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_val;
          if (skip_val == '0) begin
            phase_next = PH_DELTA;
          end
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase
    end
  end

  // Advance the parser on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_DELTA;
      running_status    <= '0;
      current_status    <= '0;
      length_accum      <= '0;
      length_bytes_seen <= '0;
      first_data_hold   <= '0;
      meta_kind         <= '0;
      skip_remaining    <= '0;
      tempo_accum       <= '0;
      tempo_bytes_seen  <= '0;
      track_clock       <= '0;
      track_finished    <= 1'b0;
      delta_hold        <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      running_status    <= running_status_next;
      current_status    <= current_status_next;
      length_accum      <= length_accum_next;
      length_bytes_seen <= length_bytes_seen_next;
      first_data_hold   <= first_data_hold_next;
      meta_kind         <= meta_kind_next;
      skip_remaining    <= skip_remaining_next;
      tempo_accum       <= tempo_accum_next;
      tempo_bytes_seen  <= tempo_bytes_seen_next;
      track_clock       <= track_clock_next;
      track_finished    <= track_finished_next;
      delta_hold        <= delta_hold_next;
    end
  end

  // Assemble the result transaction
  always_comb begin
    result.kind        = r_kind;
    result.channel     = r_channel;
    result.data0       = r_data0;
    result.data1       = r_data1;
    result.tempo_usec  = r_tempo;
    result.delta_ticks = delta_hold_next;
    result.event_time  = track_clock_next[EVENT_TIME_W-1:0];
    status.push        = fire && push;
    status.finished    = track_finished;
  end

endmodule

`default_nettype wire

@@ rtl/mtep_out_queue.sv @@
// Output register with a skid stage for result transactions.
`default_nettype none

module mtep_out_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  mtep_pkg::event_item_t push_data,
  output logic                  full,
  output logic                  valid,
  input  wire                   stall,
  output mtep_pkg::event_item_t data
);
  import mtep_pkg::*;

  event_item_t out_reg;
  event_item_t skid_reg;
  logic        out_valid;
  logic        skid_valid;
  logic        pop;

  assign pop   = out_valid && !stall;
  assign valid = out_valid;
  assign data  = out_reg;
  assign full  = skid_valid;

  // Control: hold the front entry while stalled, spill into the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else begin
      out_valid <= push;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_valid && !pop) begin
      if (push) begin
        skid_reg <= push_data;
      end
    end else if (skid_valid) begin
      out_reg <= skid_reg;
      if (push) begin
        skid_reg <= push_data;
      end
    end else if (push) begin
      out_reg <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/midi_track_event_parser_unit.sv @@
// Top level of the MIDI track event parser: input register, parser and output queue.
//
//   channel   direction  handshake                     payload
//   byte      in         byte_valid / byte_stall       byte_data  (byte_item_t)
//   event     out        event_valid / event_stall     event_data (event_item_t)
//
// One byte is taken per cycle when nothing backs up; the input register holds the
// taken byte, and the result of the single parser pass over it is loaded into the
// output register, from which the result is taken.
// Reset (rst, synchronous) clears the parser state and empties both stages.
// A stalled result is held; one more result spills into the skid stage, after
// which the input register holds its byte and byte_stall rises.
`default_nettype none

module midi_track_event_parser_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   byte_valid,
  output logic                  byte_stall,
  input  mtep_pkg::byte_item_t  byte_data,
  output logic                  event_valid,
  input  wire                   event_stall,
  output mtep_pkg::event_item_t event_data
);
  import mtep_pkg::*;

  byte_item_t   in_q;
  logic         in_q_valid;
  logic         fire;
  logic         queue_full;
  logic         accept;
  event_item_t  core_result;
  core_status_t core_status;

  assign byte_stall = in_q_valid && queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign fire       = in_q_valid && !queue_full;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= byte_data;
    end
  end

  mtep_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .result (core_result),
    .status (core_status)
  );

  mtep_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (core_status.push),
    .push_data (core_result),
    .full      (queue_full),
    .valid     (event_valid),
    .stall     (event_stall),
    .data      (event_data)
  );

  // A filled skid stage always sits behind a valid front entry
  assert property (@(posedge clk) disable iff (rst) queue_full |-> event_valid)
    else $error("skid stage full while output register empty");

  // A finished track gives no result until a new track starts
  assert property (@(posedge clk) disable iff (rst)
                   (fire && core_status.finished && !in_q.start_of_track)
                   |-> !core_status.push)
    else $error("result produced after end of track");

  // Results only come from a byte taken by the parser
  assert property (@(posedge clk) disable iff (rst) core_status.push |-> fire)
    else $error("result pushed without a byte");

  // Presented result kinds stay within the defined codes
  assert property (@(posedge clk) disable iff (rst)
                   event_valid |-> (event_data.kind <= KIND_ERROR))
    else $error("undefined result kind");

endmodule

`default_nettype wire
